// File: hw/rtl/tkc_pkg.sv
// ============================================================================
// Touch keypad calculator package
// Shared item types, key and operator codes, keypad zone tables and the
// zone classification function.
// ============================================================================
`default_nettype none

package tkc_pkg;

    // Default width of the calculator datapath.
    localparam int DATA_WIDTH_DEF = 16;

    // Field widths of the items.
    localparam int COORD_W = 10;
    localparam int KEY_W   = 5;
    localparam int OP_W    = 3;
    localparam int VALUE_W = 16;

    // Depth of the key queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Key codes.
    localparam logic [KEY_W-1:0] KEY_NONE      = 5'd0;
    localparam logic [KEY_W-1:0] KEY_DIGIT_MAX = 5'd9;
    localparam logic [KEY_W-1:0] KEY_ZERO      = 5'd10;
    localparam logic [KEY_W-1:0] KEY_CLEAR     = 5'd11;
    localparam logic [KEY_W-1:0] KEY_DIV       = 5'd12;
    localparam logic [KEY_W-1:0] KEY_ADD       = 5'd13;
    localparam logic [KEY_W-1:0] KEY_SUB       = 5'd14;
    localparam logic [KEY_W-1:0] KEY_MUL       = 5'd15;
    localparam logic [KEY_W-1:0] KEY_EQUALS    = 5'd16;

    // Pending operator codes.
    localparam logic [OP_W-1:0] OP_NONE = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd4;

    // Keypad geometry; all bounds are strict.
    localparam logic [COORD_W-1:0] NO_TOUCH_LIMIT = 10'd1000;
    localparam logic [COORD_W-1:0] ROW_EDGE [5] =
        '{10'd150, 10'd365, 10'd580, 10'd780, 10'd1000};
    localparam logic [COORD_W-1:0] COL_HI [4] = '{10'd915, 10'd745, 10'd515, 10'd290};
    localparam logic [COORD_W-1:0] COL_LO [4] = '{10'd745, 10'd515, 10'd290, 10'd100};
    localparam logic [KEY_W-1:0] ZONE_KEY [4][4] = '{
        '{5'd1,  5'd4,  5'd7,  5'd11},
        '{5'd2,  5'd5,  5'd8,  5'd10},
        '{5'd3,  5'd6,  5'd9,  5'd12},
        '{5'd13, 5'd14, 5'd15, 5'd16}
    };

    // Back end sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EXEC,
        BK_DIV,
        BK_FIN
    } bk_state_t;

    // One touch sample.
    typedef struct packed {
        logic [COORD_W-1:0] x_sample;
        logic [COORD_W-1:0] y_sample;
    } in_item_t;

    // One calculator result.
    typedef struct packed {
        logic [KEY_W-1:0]          key_code;
        logic                      pressed;
        logic signed [VALUE_W-1:0] entry_value;
        logic signed [VALUE_W-1:0] first_operand;
        logic [OP_W-1:0]           pending_op;
        logic signed [VALUE_W-1:0] answer;
        logic                      div_error;
    } out_item_t;

    // Maps a sample to its keypad zone. Rows and columns do not overlap,
    // so at most one zone matches.
    function automatic logic [KEY_W-1:0] classify_key(
        input logic [COORD_W-1:0] x,
        input logic [COORD_W-1:0] y
    );
        logic [KEY_W-1:0] key;
        key = KEY_NONE;
        if (!(x > NO_TOUCH_LIMIT && y > NO_TOUCH_LIMIT))
        begin
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    if (y > ROW_EDGE[r] && y < ROW_EDGE[r+1] &&
                        x > COL_LO[c] && x < COL_HI[c])
                    begin
                        key = ZONE_KEY[r][c];
                    end
                end
            end
        end
        return key;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tkc_front.sv
// ============================================================================
// Touch keypad front end
// Accepts touch samples, sorts each into a key code and hands it to the
// key queue through a one-entry holding register.
// ============================================================================
`default_nettype none

module tkc_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          sample_valid,
    output logic                               sample_stall,
    input  wire tkc_pkg::in_item_t             sample,
    output logic                               push,
    output logic [tkc_pkg::KEY_W-1:0]          push_key,
    input  wire logic                          queue_ready
);

    logic                     hold_valid_reg;
    logic                     hold_valid_next;
    logic [tkc_pkg::KEY_W-1:0] hold_key_reg;
    logic                     accept;

    // Handshake: the holding register frees up as soon as the queue takes it.
    always_comb
    begin
        push            = hold_valid_reg && queue_ready;
        sample_stall    = hold_valid_reg && !queue_ready;
        accept          = sample_valid && !sample_stall;
        push_key        = hold_key_reg;
        hold_valid_next = accept ? 1'b1 : (push ? 1'b0 : hold_valid_reg);
    end

    // Valid flag of the holding register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    // Classified key of the accepted sample.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_key_reg <= tkc_pkg::classify_key(sample.x_sample, sample.y_sample);
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/tkc_queue.sv
// ============================================================================
// Touch keypad key queue
// Short first-in first-out queue of key codes between the front and back.
// ============================================================================
`default_nettype none

module tkc_queue (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      push,
    input  wire logic [tkc_pkg::KEY_W-1:0] push_key,
    output logic                           ready,
    output logic                           pop_valid,
    output logic [tkc_pkg::KEY_W-1:0]      pop_key,
    input  wire logic                      pop
);

    localparam int DEPTH = tkc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [tkc_pkg::KEY_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]          wr_ptr_reg;
    logic [PTR_W-1:0]          rd_ptr_reg;
    logic [CNT_W-1:0]          count_reg;
    logic                      do_push;
    logic                      do_pop;

    // Status toward both sides.
    always_comb
    begin
        ready     = count_reg != CNT_W'(DEPTH);
        pop_valid = count_reg != '0;
        pop_key   = entry_reg[rd_ptr_reg];
        do_push   = push && ready;
        do_pop    = pop && pop_valid;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_key;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/tkc_divider.sv
// ============================================================================
// Touch keypad divider
// Iterative signed divider, one quotient bit per cycle, truncating toward
// zero. The divisor must be nonzero.
// ============================================================================
`default_nettype none

module tkc_divider #(
    parameter int DATA_WIDTH = tkc_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DATA_WIDTH-1:0] dividend,
    input  wire logic [DATA_WIDTH-1:0] divisor,
    output logic                       done,
    output logic [DATA_WIDTH-1:0]      quotient
);

    localparam int CNT_W = $clog2(DATA_WIDTH + 1);

    logic [DATA_WIDTH-1:0] rem_reg;
    logic [DATA_WIDTH-1:0] quo_reg;
    logic [DATA_WIDTH-1:0] den_reg;
    logic                  neg_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH:0]   diff;
    logic [DATA_WIDTH-1:0] dividend_mag;
    logic [DATA_WIDTH-1:0] divisor_mag;

    // One restoring step and the operand magnitudes.
    always_comb
    begin
        shifted      = {rem_reg, quo_reg[DATA_WIDTH-1]};
        diff         = shifted - {1'b0, den_reg};
        dividend_mag = dividend[DATA_WIDTH-1] ? (~dividend + 1'b1) : dividend;
        divisor_mag  = divisor[DATA_WIDTH-1] ? (~divisor + 1'b1) : divisor;
        done         = done_reg;
        quotient     = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    end

    // Control: busy flag, step count and done pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DATA_WIDTH);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: the quotient shifts in as the dividend shifts out.
    // The partial remainder stays below the divisor, so it fits the data width.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend_mag;
            den_reg <= divisor_mag;
            neg_reg <= dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
        end
        else if (busy_reg)
        begin
            if (!diff[DATA_WIDTH])
            begin
                rem_reg <= diff[DATA_WIDTH-1:0];
                quo_reg <= {quo_reg[DATA_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[DATA_WIDTH-1:0];
                quo_reg <= {quo_reg[DATA_WIDTH-2:0], 1'b0};
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/tkc_back.sv
// ============================================================================
// Touch keypad back end
// Takes key codes from the queue, runs the calculator state and presents
// one result item per key in an output register.
// ============================================================================
`default_nettype none

module tkc_back #(
    parameter int DATA_WIDTH = tkc_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      key_valid,
    input  wire logic [tkc_pkg::KEY_W-1:0] key,
    output logic                           key_pop,
    output logic                           result_valid,
    input  wire logic                      result_stall,
    output tkc_pkg::out_item_t             result
);

    localparam int DW = DATA_WIDTH;
    localparam int VW = tkc_pkg::VALUE_W;

    tkc_pkg::bk_state_t        state_reg, state_next;
    logic                      held_reg, held_next;
    logic [DW-1:0]             entry_reg, entry_next;
    logic [DW-1:0]             operand_reg, operand_next;
    logic [tkc_pkg::OP_W-1:0]  op_reg, op_next;
    logic [DW-1:0]             answer_reg, answer_next;
    logic                      error_reg, error_next;
    logic [tkc_pkg::KEY_W-1:0] key_reg, key_next;
    logic [DW-1:0]             res_reg, res_next;
    logic                      res_err_reg, res_err_next;
    logic                      out_valid_reg, out_valid_next;
    tkc_pkg::out_item_t        out_reg, out_next;
    logic                      out_load;
    logic                      slot_free;
    logic                      div_start;
    logic                      div_done;
    logic [DW-1:0]             div_quo;

    tkc_divider #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (operand_reg),
        .divisor  (entry_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Sequencer: key actions, equals evaluation and result assembly.
    always_comb
    begin
        state_next   = state_reg;
        held_next    = held_reg;
        entry_next   = entry_reg;
        operand_next = operand_reg;
        op_next      = op_reg;
        answer_next  = answer_reg;
        error_next   = error_reg;
        key_next     = key_reg;
        res_next     = res_reg;
        res_err_next = res_err_reg;
        key_pop      = 1'b0;
        div_start    = 1'b0;
        out_load     = 1'b0;
        slot_free    = !out_valid_reg || !result_stall;

        unique case (state_reg)
            tkc_pkg::BK_IDLE:
            begin
                if (key_valid && slot_free)
                begin
                    key_pop   = 1'b1;
                    key_next  = key;
                    held_next = key != tkc_pkg::KEY_NONE;
                    out_load  = 1'b1;
                    // A key acts only on the release-to-press edge.
                    if (key != tkc_pkg::KEY_NONE && !held_reg)
                    begin
                        priority if (key <= tkc_pkg::KEY_DIGIT_MAX)
                        begin
                            entry_next = DW'(entry_reg * 10) + DW'(key);
                        end
                        else if (key == tkc_pkg::KEY_ZERO)
                        begin
                            entry_next = DW'(entry_reg * 10);
                        end
                        else if (key == tkc_pkg::KEY_CLEAR)
                        begin
                            entry_next   = '0;
                            operand_next = '0;
                            answer_next  = '0;
                            op_next      = tkc_pkg::OP_NONE;
                            error_next   = 1'b0;
                        end
                        else if (key == tkc_pkg::KEY_EQUALS)
                        begin
                            // Equals without a valid pending operator changes nothing.
                            if (op_reg >= tkc_pkg::OP_ADD && op_reg <= tkc_pkg::OP_DIV)
                            begin
                                state_next = tkc_pkg::BK_EXEC;
                                out_load   = 1'b0;
                            end
                        end
                        else
                        begin
                            // Operator keys latch the entry as the first operand.
                            operand_next = entry_reg;
                            entry_next   = '0;
                            unique case (key)
                                tkc_pkg::KEY_DIV: op_next = tkc_pkg::OP_DIV;
                                tkc_pkg::KEY_ADD: op_next = tkc_pkg::OP_ADD;
                                tkc_pkg::KEY_SUB: op_next = tkc_pkg::OP_SUB;
                                default:          op_next = tkc_pkg::OP_MUL;
                            endcase
                        end
                    end
                end
            end

            tkc_pkg::BK_EXEC:
            begin
                res_err_next = 1'b0;
                state_next   = tkc_pkg::BK_FIN;
                unique case (op_reg)
                    tkc_pkg::OP_ADD: res_next = operand_reg + entry_reg;
                    tkc_pkg::OP_SUB: res_next = operand_reg - entry_reg;
                    tkc_pkg::OP_MUL: res_next = DW'(operand_reg * entry_reg);
                    default:
                    begin
                        // Divide: a zero divisor gives zero and flags an error.
                        if (entry_reg == '0)
                        begin
                            res_next     = '0;
                            res_err_next = 1'b1;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = tkc_pkg::BK_DIV;
                        end
                    end
                endcase
            end

            tkc_pkg::BK_DIV:
            begin
                if (div_done)
                begin
                    res_next   = div_quo;
                    state_next = tkc_pkg::BK_FIN;
                end
            end

            tkc_pkg::BK_FIN:
            begin
                answer_next  = res_reg;
                error_next   = res_err_reg;
                entry_next   = '0;
                operand_next = '0;
                op_next      = tkc_pkg::OP_NONE;
                out_load     = 1'b1;
                state_next   = tkc_pkg::BK_IDLE;
            end

            default:
            begin
                state_next = tkc_pkg::BK_IDLE;
            end
        endcase

        // Result item from the updated state.
        out_next.key_code      = key_next;
        out_next.pressed       = held_next;
        out_next.entry_value   = VW'(entry_next);
        out_next.first_operand = VW'(operand_next);
        out_next.pending_op    = op_next;
        out_next.answer        = VW'(answer_next);
        out_next.div_error     = error_next;

        out_valid_next = out_load ? 1'b1 : (slot_free ? 1'b0 : out_valid_reg);
        result_valid   = out_valid_reg;
        result         = out_reg;
    end

    // Calculator state and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tkc_pkg::BK_IDLE;
            held_reg      <= 1'b0;
            entry_reg     <= '0;
            operand_reg   <= '0;
            op_reg        <= tkc_pkg::OP_NONE;
            answer_reg    <= '0;
            error_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            entry_reg     <= entry_next;
            operand_reg   <= operand_next;
            op_reg        <= op_next;
            answer_reg    <= answer_next;
            error_reg     <= error_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        res_reg     <= res_next;
        res_err_reg <= res_err_next;
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/touch_keypad_calculator_top.sv
// ============================================================================
// Touch keypad calculator
// Sorts touch samples into keypad keys and runs a four-function calculator.
// ============================================================================
// Usage: the sample channel takes one touch item (x_sample, y_sample) per
// accepted handshake; the result channel returns exactly one item per
// sample, in order, with the key code, held flag and calculator state.
// An item is taken at a clock edge where valid is high and stall is low.
// Each key passes the front holding register, where it is classified, the
// key queue, and the back end, which updates the state and loads the output
// register. An equals key with a pending operator also passes the execute
// and finish states, and a divide waits in the divide state for the divider.
// Ordinary keys flow at one item per cycle while the receiver does not
// stall; the back end sequencer takes no new key while it evaluates an equals.
// Reset clears all calculator state, the queue and both valid flags.
// When the receiver stalls, the result holds in the output register, the
// key queue and the front holding register fill, and then sample_stall
// rises until the receiver takes the waiting result.
// ============================================================================
`default_nettype none

module touch_keypad_calculator_top #(
    parameter int DATA_WIDTH = tkc_pkg::DATA_WIDTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              sample_valid,
    output logic                   sample_stall,
    input  wire tkc_pkg::in_item_t sample,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output tkc_pkg::out_item_t     result
);

    logic                      push;
    logic [tkc_pkg::KEY_W-1:0] push_key;
    logic                      queue_ready;
    logic                      key_valid;
    logic [tkc_pkg::KEY_W-1:0] key;
    logic                      key_pop;

    tkc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .push         (push),
        .push_key     (push_key),
        .queue_ready  (queue_ready)
    );

    tkc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_key  (push_key),
        .ready     (queue_ready),
        .pop_valid (key_valid),
        .pop_key   (key),
        .pop       (key_pop)
    );

    tkc_back #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_valid    (key_valid),
        .key          (key),
        .key_pop      (key_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

`ifndef SYNTH
    // The back end takes a key only when the output register can hold its result.
    assert property (@(posedge clk) disable iff (!rst_n)
        key_pop |-> (key_valid && (!result_valid || !result_stall)))
        else $error("key taken without room for its result");

    // A divide-by-zero error always comes with a zero answer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.div_error) |-> (result.answer == '0))
        else $error("error flag set with a nonzero answer");

    // The held flag follows whether the sample hit a key.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.pressed == (result.key_code != tkc_pkg::KEY_NONE)))
        else $error("held flag disagrees with key code");

    // Only defined operator codes are ever pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.pending_op <= tkc_pkg::OP_DIV))
        else $error("undefined pending operator");
`endif

endmodule

`default_nettype wire
